>>> rtl/asfc_pkg.sv
// Shared types, format codes and small helper functions for the audio
// sample format converter. No dependencies.
`timescale 1ns / 1ps

package asfc_pkg;

   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   localparam logic [3:0] FMT_I16 = 4'd0;
   localparam logic [3:0] FMT_I24 = 4'd1;
   localparam logic [3:0] FMT_I32 = 4'd2;
   localparam logic [3:0] FMT_F32 = 4'd3;
   localparam logic [3:0] FMT_F64 = 4'd4;
   localparam logic [3:0] FMT_R16 = 4'd5;
   localparam logic [3:0] FMT_R18 = 4'd6;
   localparam logic [3:0] FMT_R20 = 4'd7;
   localparam logic [3:0] FMT_R24 = 4'd8;

   localparam logic [30:0] SCALE_I16 = 31'd32767;
   localparam logic [30:0] SCALE_I24 = 31'd8388607;
   localparam logic [30:0] SCALE_I32 = 31'd2147483647;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } pipe_ctl_type;

   typedef enum logic [1:0] {
      KIND_I16,
      KIND_I24,
      KIND_I32
   } kind_type;

   typedef enum logic [1:0] {
      DMODE_INT,
      DMODE_F64N,
      DMODE_F64S,
      DMODE_SPEC
   } dmode_type;

   function automatic logic [4:0] align_shift(input logic [3:0] fmt);
      logic [4:0] sh;
      case (fmt)
         FMT_R16: sh = 5'd16;
         FMT_R18: sh = 5'd14;
         FMT_R20: sh = 5'd12;
         FMT_R24: sh = 5'd8;
         default: sh = 5'd0;
      endcase
      return sh;
   endfunction

   function automatic logic [3:0] sample_bytes(input logic [3:0] fmt);
      logic [3:0] b;
      case (fmt)
         FMT_I16: b = 4'd2;
         FMT_I24: b = 4'd3;
         FMT_F64: b = 4'd8;
         default: b = 4'd4;
      endcase
      return b;
   endfunction

   // position of the highest set bit, 0 when none
   function automatic logic [4:0] msb_pos32(input logic [31:0] x);
      logic [4:0] p;
      p = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) p = 5'(i);
      end
      return p;
   endfunction

endpackage

>>> rtl/asfc_enc.sv
// Encode datapath: float32 to device sample, three register stages.
// Depends on asfc_pkg.
`timescale 1ns / 1ps

module asfc_enc (
   input  logic                   clock,
   input  asfc_pkg::pipe_ctl_type ctl,
   input  logic [3:0]             format,
   input  logic [31:0]            fbits,
   output logic [63:0]            data_out
);

   // ---- stage 1: classify, clamp, scale multiply
   logic        sgn;
   logic [7:0]  ef;
   logic [22:0] fr;
   logic        is_nan;
   logic        clamp;
   logic [23:0] mant;
   logic [7:0]  ee;
   logic [7:0]  rr;
   logic [30:0] scale;
   logic [4:0]  dp;
   logic [63:0] f64w;

   logic                 sgn1_ff, sgn1_in;
   logic                 zero1_ff, zero1_in;
   logic                 dir1_ff, dir1_in;
   logic [63:0]          dval1_ff, dval1_in;
   logic [54:0]          prod1_ff, prod1_in;
   logic [5:0]           rsh1_ff, rsh1_in;
   logic [4:0]           sh1_ff, sh1_in;
   asfc_pkg::kind_type   kind1_ff, kind1_in;

   always_comb begin
      sgn    = fbits[31];
      ef     = fbits[30:23];
      fr     = fbits[22:0];
      is_nan = (ef == 8'hFF) && (fr != 23'd0);
      clamp  = (ef > 8'd127) || ((ef == 8'd127) && (fr != 23'd0));
      mant   = clamp ? 24'h800000 : {1'b1, fr};
      ee     = clamp ? 8'd127 : ef;
      rr     = 8'd150 - ee;

      case (format)
         asfc_pkg::FMT_I16: begin
            kind1_in = asfc_pkg::KIND_I16;
            scale    = asfc_pkg::SCALE_I16;
         end
         asfc_pkg::FMT_I24: begin
            kind1_in = asfc_pkg::KIND_I24;
            scale    = asfc_pkg::SCALE_I24;
         end
         default: begin
            kind1_in = asfc_pkg::KIND_I32;
            scale    = asfc_pkg::SCALE_I32;
         end
      endcase

      // widening to double; subnormals are renormalized
      dp = asfc_pkg::msb_pos32({9'd0, fr});
      if (is_nan) begin
         f64w = {sgn, 11'h7FF, 1'b1 | fr[22], fr[21:0], 29'd0};
      end else if (ef == 8'hFF) begin
         f64w = {sgn, 11'h7FF, 52'd0};
      end else if (ef == 8'd0) begin
         if (fr == 23'd0) begin
            f64w = {sgn, 63'd0};
         end else begin
            f64w = {sgn, 11'(dp) + 11'd874, 52'({29'd0, fr} << (6'd52 - 6'(dp)))};
         end
      end else begin
         f64w = {sgn, 11'(ef) + 11'd896, fr, 29'd0};
      end

      sgn1_in  = sgn;
      zero1_in = is_nan || (ef == 8'd0);
      dir1_in  = (format == asfc_pkg::FMT_F32) || (format == asfc_pkg::FMT_F64);
      dval1_in = (format == asfc_pkg::FMT_F32) ? {32'd0, fbits} : f64w;
      prod1_in = 55'(mant) * 55'(scale);
      rsh1_in  = (rr >= 8'd58) ? 6'd63 : rr[5:0];
      sh1_in   = asfc_pkg::align_shift(format);
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         sgn1_ff  <= sgn1_in;
         zero1_ff <= zero1_in;
         dir1_ff  <= dir1_in;
         dval1_ff <= dval1_in;
         prod1_ff <= prod1_in;
         rsh1_ff  <= rsh1_in;
         sh1_ff   <= sh1_in;
         kind1_ff <= kind1_in;
      end
   end

   // ---- stage 2: round product to the working precision
   logic        top;
   logic [5:0]  dr;
   logic [55:0] px;
   logic [55:0] unit;
   logic [55:0] mask2;
   logic [55:0] low2;
   logic [55:0] half2;
   logic        up2;

   logic                 sgn2_ff, sgn2_in;
   logic                 zero2_ff, zero2_in;
   logic                 dir2_ff, dir2_in;
   logic [63:0]          dval2_ff, dval2_in;
   logic [55:0]          p2_ff, p2_in;
   logic [5:0]           rsh2_ff, rsh2_in;
   logic [4:0]           sh2_ff, sh2_in;
   asfc_pkg::kind_type   kind2_ff, kind2_in;

   always_comb begin
      case (kind1_ff)
         asfc_pkg::KIND_I16: begin
            top = prod1_ff[38];
            dr  = top ? 6'd15 : 6'd14;
         end
         asfc_pkg::KIND_I24: begin
            top = prod1_ff[46];
            dr  = top ? 6'd23 : 6'd22;
         end
         default: begin
            top = prod1_ff[54];
            dr  = top ? 6'd2 : 6'd1;
         end
      endcase
      px    = {1'b0, prod1_ff};
      unit  = 56'd1 << dr;
      mask2 = unit - 56'd1;
      half2 = 56'd1 << (dr - 6'd1);
      low2  = px & mask2;
      up2   = (low2 > half2) || ((low2 == half2) && ((px & unit) != 56'd0));
      p2_in = (px & ~mask2) + (up2 ? unit : 56'd0);

      sgn2_in  = sgn1_ff;
      zero2_in = zero1_ff;
      dir2_in  = dir1_ff;
      dval2_in = dval1_ff;
      rsh2_in  = rsh1_ff;
      sh2_in   = sh1_ff;
      kind2_in = kind1_ff;
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         sgn2_ff  <= sgn2_in;
         zero2_ff <= zero2_in;
         dir2_ff  <= dir2_in;
         dval2_ff <= dval2_in;
         p2_ff    <= p2_in;
         rsh2_ff  <= rsh2_in;
         sh2_ff   <= sh2_in;
         kind2_ff <= kind2_in;
      end
   end

   // ---- stage 3: round to integer, apply sign, align
   logic [63:0]        x3;
   logic [63:0]        one3;
   logic [63:0]        mask3;
   logic [63:0]        half3;
   logic [63:0]        low3;
   logic [63:0]        q3;
   logic               up3;
   logic [31:0]        n3;
   logic [31:0]        val3;
   logic signed [31:0] sval;
   logic signed [31:0] aval;
   logic [63:0]        res_ff, res_in;

   always_comb begin
      x3    = {8'd0, p2_ff};
      one3  = 64'd1 << rsh2_ff;
      mask3 = one3 - 64'd1;
      half3 = one3 >> 1;
      q3    = x3 >> rsh2_ff;
      low3  = x3 & mask3;
      up3   = (low3 > half3) || ((low3 == half3) && q3[0]);
      n3    = q3[31:0] + {31'd0, up3};
      val3  = sgn2_ff ? (32'd0 - n3) : n3;
      sval  = val3;
      aval  = sval >>> sh2_ff;

      if (dir2_ff) begin
         res_in = dval2_ff;
      end else if (zero2_ff) begin
         res_in = 64'd0;
      end else begin
         case (kind2_ff)
            asfc_pkg::KIND_I16: res_in = {48'd0, val3[15:0]};
            asfc_pkg::KIND_I24: res_in = {40'd0, val3[23:0]};
            default:            res_in = {32'd0, aval};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         res_ff <= res_in;
      end
   end

   assign data_out = res_ff;

endmodule

>>> rtl/asfc_dec.sv
// Decode datapath: device sample to float32, three register stages.
// Depends on asfc_pkg.
`timescale 1ns / 1ps

module asfc_dec (
   input  logic                   clock,
   input  asfc_pkg::pipe_ctl_type ctl,
   input  logic [3:0]             format,
   input  logic [63:0]            data_in,
   output logic [63:0]            data_out
);

   // ---- stage 1: sign-extend and take magnitude, classify double
   logic [31:0] xs;
   logic [31:0] ua;
   logic        dsg;
   logic [10:0] ex;
   logic [51:0] man;
   logic [11:0] dd;

   logic                  sgn1_ff, sgn1_in;
   logic [31:0]           mag1_ff, mag1_in;
   logic [7:0]            bias1_ff, bias1_in;
   logic [51:0]           man1_ff, man1_in;
   logic [7:0]            expf1_ff, expf1_in;
   logic [5:0]            drop1_ff, drop1_in;
   logic [31:0]           spec1_ff, spec1_in;
   asfc_pkg::dmode_type   mode1_ff, mode1_in;

   always_comb begin
      ua  = data_in[31:0] << asfc_pkg::align_shift(format);
      dsg = data_in[63];
      ex  = data_in[62:52];
      man = data_in[51:0];
      dd  = 12'd926 - {1'b0, ex};

      case (format)
         asfc_pkg::FMT_I16: begin
            xs       = {{16{data_in[15]}}, data_in[15:0]};
            bias1_in = 8'd112;
         end
         asfc_pkg::FMT_I24: begin
            xs       = {{8{data_in[23]}}, data_in[23:0]};
            bias1_in = 8'd104;
         end
         default: begin
            xs       = ua;
            bias1_in = 8'd96;
         end
      endcase

      mag1_in  = xs[31] ? (32'd0 - xs) : xs;
      man1_in  = man;
      expf1_in = 8'(ex - 11'd896);
      drop1_in = (dd > 12'd63) ? 6'd63 : dd[5:0];
      sgn1_in  = xs[31];
      spec1_in = 32'd0;
      mode1_in = asfc_pkg::DMODE_INT;

      if (format == asfc_pkg::FMT_F32) begin
         mode1_in = asfc_pkg::DMODE_SPEC;
         spec1_in = data_in[31:0];
      end else if (format == asfc_pkg::FMT_F64) begin
         sgn1_in = dsg;
         if ((ex == 11'h7FF) && (man != 52'd0)) begin
            mode1_in = asfc_pkg::DMODE_SPEC;
            spec1_in = {dsg, 8'hFF, 1'b1, man[50:29]};
         end else if (ex >= 11'd1151) begin
            // too large for single, infinities included
            mode1_in = asfc_pkg::DMODE_SPEC;
            spec1_in = {dsg, 8'hFF, 23'd0};
         end else if (ex == 11'd0) begin
            mode1_in = asfc_pkg::DMODE_SPEC;
            spec1_in = {dsg, 31'd0};
         end else if (ex >= 11'd897) begin
            mode1_in = asfc_pkg::DMODE_F64N;
         end else begin
            mode1_in = asfc_pkg::DMODE_F64S;
         end
      end else if (mag1_in == 32'd0) begin
         mode1_in = asfc_pkg::DMODE_SPEC;
         spec1_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         sgn1_ff  <= sgn1_in;
         mag1_ff  <= mag1_in;
         bias1_ff <= bias1_in;
         man1_ff  <= man1_in;
         expf1_ff <= expf1_in;
         drop1_ff <= drop1_in;
         spec1_ff <= spec1_in;
         mode1_ff <= mode1_in;
      end
   end

   // ---- stage 2: normalize / denormalize, split off guard and sticky
   logic [4:0]  p2;
   logic [31:0] nm;
   logic [63:0] sig;
   logic [63:0] kept;
   logic [63:0] lowm;

   logic        sgn2_ff, sgn2_in;
   logic [30:0] base2_ff, base2_in;
   logic        g2_ff, g2_in;
   logic        st2_ff, st2_in;
   logic        spc2_ff, spc2_in;
   logic [31:0] spec2_ff, spec2_in;

   always_comb begin
      p2   = asfc_pkg::msb_pos32(mag1_ff);
      nm   = mag1_ff << (5'd31 - p2);
      sig  = {11'd0, 1'b1, man1_ff};
      kept = sig >> drop1_ff;
      lowm = (64'd1 << (drop1_ff - 6'd1)) - 64'd1;

      sgn2_in  = sgn1_ff;
      spc2_in  = 1'b0;
      spec2_in = spec1_ff;
      case (mode1_ff)
         asfc_pkg::DMODE_INT: begin
            base2_in = {bias1_ff + {3'd0, p2}, nm[30:8]};
            g2_in    = nm[7];
            st2_in   = nm[6:0] != 7'd0;
         end
         asfc_pkg::DMODE_F64N: begin
            base2_in = {expf1_ff, man1_ff[51:29]};
            g2_in    = man1_ff[28];
            st2_in   = man1_ff[27:0] != 28'd0;
         end
         asfc_pkg::DMODE_F64S: begin
            base2_in = {8'd0, kept[22:0]};
            g2_in    = sig[drop1_ff - 6'd1];
            st2_in   = (sig & lowm) != 64'd0;
         end
         default: begin
            base2_in = 31'd0;
            g2_in    = 1'b0;
            st2_in   = 1'b0;
            spc2_in  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.en2) begin
         sgn2_ff  <= sgn2_in;
         base2_ff <= base2_in;
         g2_ff    <= g2_in;
         st2_ff   <= st2_in;
         spc2_ff  <= spc2_in;
         spec2_ff <= spec2_in;
      end
   end

   // ---- stage 3: round to nearest even; a carry runs into the exponent
   logic        up3;
   logic [31:0] res_ff, res_in;

   always_comb begin
      up3    = g2_ff && (st2_ff || base2_ff[0]);
      res_in = spc2_ff ? spec2_ff : {sgn2_ff, base2_ff + {30'd0, up3}};
   end

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         res_ff <= res_in;
      end
   end

   assign data_out = {32'd0, res_ff};

endmodule

>>> rtl/audio_sample_format_converter_top.sv
// Audio sample format converter, top level: handshake pipeline control,
// sideband pipeline and result select. Depends on asfc_pkg, asfc_enc, asfc_dec.
`timescale 1ns / 1ps

// Converts one audio sample per beat between float32 and int16, packed
// int24, int32, right-aligned int32 (16/18/20/24), float32 and float64.
// Throughput is one sample per clock when no stall holds the pipe. There are three
// register stages (scale multiply, precision rounding, integer rounding /
// packing); a request is registered into v1, v2 and v3 in turn, and rsp_valid
// is v3. A stall on the result side backs up through the stages and reaches
// req_stall only when every stage holds a sample. No state is kept between
// samples.
module audio_sample_format_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [3:0]  req_format,
   input  logic [63:0] req_data_in,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_data_out,
   output logic [3:0]  rsp_sample_bytes,
   output logic        rsp_last_out
);

   asfc_pkg::pipe_ctl_type ctl;
   logic rdy1, rdy2, rdy3;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic cmd1_ff, cmd2_ff, cmd3_ff;
   logic [3:0] fmt1_ff, fmt2_ff, fmt3_ff;
   logic last1_ff, last2_ff, last3_ff;
   logic [63:0] enc_out, dec_out;

   assign rdy3 = !v3_ff || !rsp_stall;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign ctl  = '{en1: rdy1, en2: rdy2, en3: rdy3};
   assign req_stall = !rdy1;

   assign v1_in = rdy1 ? req_valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         cmd1_ff  <= req_cmd;
         fmt1_ff  <= req_format;
         last1_ff <= req_last_in;
      end
      if (ctl.en2) begin
         cmd2_ff  <= cmd1_ff;
         fmt2_ff  <= fmt1_ff;
         last2_ff <= last1_ff;
      end
      if (ctl.en3) begin
         cmd3_ff  <= cmd2_ff;
         fmt3_ff  <= fmt2_ff;
         last3_ff <= last2_ff;
      end
   end

   asfc_enc u_enc (
      .clock    (clock),
      .ctl      (ctl),
      .format   (req_format),
      .fbits    (req_data_in[31:0]),
      .data_out (enc_out)
   );

   asfc_dec u_dec (
      .clock    (clock),
      .ctl      (ctl),
      .format   (req_format),
      .data_in  (req_data_in),
      .data_out (dec_out)
   );

   assign rsp_valid        = v3_ff;
   assign rsp_data_out     = (cmd3_ff == asfc_pkg::CMD_DECODE) ? dec_out : enc_out;
   assign rsp_sample_bytes = asfc_pkg::sample_bytes(fmt3_ff);
   assign rsp_last_out     = last3_ff;

   // back-pressure only when the whole pipe is full and the output is held
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("req_stall raised with room in the pipe");

   a_dec_upper: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cmd3_ff == asfc_pkg::CMD_DECODE)) |-> (rsp_data_out[63:32] == 32'd0))
      else $error("decoded float has upper word set");

   a_i16_upper: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cmd3_ff == asfc_pkg::CMD_ENCODE) && (fmt3_ff == asfc_pkg::FMT_I16))
      |-> (rsp_data_out[63:16] == 48'd0))
      else $error("int16 sample has bits above 16");

endmodule
